### sv/bmhq_pkg.sv
package bmhq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LINK_W    = IDX_W + 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR_FULL,
        OP_ERR_EMPTY,
        OP_PUSH_INIT,
        OP_POP_INIT,
        OP_POP_KEY,
        OP_READ_UP,
        OP_UP_STEP,
        OP_READ_DOWN,
        OP_DOWN_STEP,
        OP_PLACE,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_CHECK,
        S_UP_STEP,
        S_POP_KEY,
        S_DOWN_CHECK,
        S_DOWN_STEP,
        S_RESULT
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic kind_pop;
        logic pos_zero;
        logic up_more;
        logic has_left;
        logic down_more;
        logic out_free;
    } dp_status_t;

endpackage

### sv/bmhq_ctrl.sv
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (status.kind_pop) begin
                    if (status.empty) begin
                        cmd.op     = OP_ERR_EMPTY;
                        state_next = S_RESULT;
                    end else begin
                        cmd.op     = OP_POP_INIT;
                        state_next = S_POP_KEY;
                    end
                end else begin
                    if (status.full) begin
                        cmd.op     = OP_ERR_FULL;
                        state_next = S_RESULT;
                    end else begin
                        cmd.op     = OP_PUSH_INIT;
                        state_next = S_UP_CHECK;
                    end
                end
            end
            S_UP_CHECK: begin
                if (status.pos_zero) begin
                    cmd.op     = OP_PLACE;
                    state_next = S_RESULT;
                end else begin
                    cmd.op     = OP_READ_UP;
                    state_next = S_UP_STEP;
                end
            end
            S_UP_STEP: begin
                if (status.up_more) begin
                    cmd.op     = OP_UP_STEP;
                    state_next = S_UP_CHECK;
                end else begin
                    cmd.op     = OP_PLACE;
                    state_next = S_RESULT;
                end
            end
            S_POP_KEY: begin
                cmd.op     = OP_POP_KEY;
                state_next = S_DOWN_CHECK;
            end
            S_DOWN_CHECK: begin
                if (status.has_left) begin
                    cmd.op     = OP_READ_DOWN;
                    state_next = S_DOWN_STEP;
                end else begin
                    cmd.op     = OP_PLACE;
                    state_next = S_RESULT;
                end
            end
            S_DOWN_STEP: begin
                if (status.down_more) begin
                    cmd.op     = OP_DOWN_STEP;
                    state_next = S_DOWN_CHECK;
                end else begin
                    cmd.op     = OP_PLACE;
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (status.out_free) begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/bmhq_datapath.sv
module bmhq_datapath
    import bmhq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_tdata,
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    input  dp_cmd_t     cmd,
    output dp_status_t  status
);

    logic [KEY_WIDTH-1:0] heap_mem [CAPACITY];

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] root_reg;
    logic [KEY_WIDTH-1:0] rd_a_reg;
    logic [KEY_WIDTH-1:0] rd_b_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 kind_reg;
    err_t                 err_reg;

    logic                 m_valid_reg;
    logic [31:0]          out_top_reg;
    logic                 out_empty_reg;
    logic [6:0]           out_count_reg;
    err_t                 out_err_reg;

    logic [63:0]          in_ext;
    logic [63:0]          root_ext;
    logic [CNT_W-1:0]     cnt_dec;
    logic [IDX_W-1:0]     pos_dec;
    logic [IDX_W-1:0]     parent_idx;
    logic [LINK_W-1:0]    left_idx;
    logic [LINK_W-1:0]    right_idx;
    logic [LINK_W-1:0]    count_link;
    logic                 has_right;
    logic                 pick_right;
    logic [KEY_WIDTH-1:0] pick_val;
    logic [IDX_W-1:0]     pick_idx;
    logic [IDX_W-1:0]     rd_a_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 out_free;

    assign in_ext     = 64'(signed'(s_tdata));
    assign root_ext   = 64'(signed'(root_reg));
    assign cnt_dec    = count_reg - CNT_W'(1);
    assign pos_dec    = pos_reg - IDX_W'(1);
    assign parent_idx = pos_dec >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + LINK_W'(1);
    assign count_link = LINK_W'(count_reg);
    assign has_right  = right_idx < count_link;
    assign pick_right = has_right && ($signed(rd_a_reg) > $signed(rd_b_reg));
    assign pick_val   = pick_right ? rd_b_reg : rd_a_reg;
    assign pick_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
    assign out_free   = !m_valid_reg || m_tready;

    assign status.full      = count_reg == CNT_W'(CAPACITY);
    assign status.empty     = count_reg == '0;
    assign status.kind_pop  = kind_reg == KIND_POP;
    assign status.pos_zero  = pos_reg == '0;
    assign status.up_more   = $signed(rd_a_reg) > $signed(key_reg);
    assign status.has_left  = left_idx < count_link;
    assign status.down_more = $signed(key_reg) > $signed(pick_val);
    assign status.out_free  = out_free;

    always_comb begin
        rd_a_addr = left_idx[IDX_W-1:0];
        case (cmd.op)
            OP_POP_INIT: rd_a_addr = cnt_dec[IDX_W-1:0];
            OP_READ_UP:  rd_a_addr = parent_idx;
            default:     rd_a_addr = left_idx[IDX_W-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = key_reg;
        case (cmd.op)
            OP_UP_STEP: begin
                wr_en   = 1'b1;
                wr_data = rd_a_reg;
            end
            OP_DOWN_STEP: begin
                wr_en   = 1'b1;
                wr_data = pick_val;
            end
            OP_PLACE: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[right_idx[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr == '0) begin
            root_reg <= wr_data;
        end
        case (cmd.op)
            OP_LOAD: begin
                key_reg  <= in_ext[KEY_WIDTH-1:0];
                kind_reg <= s_tuser[0];
            end
            OP_PUSH_INIT: pos_reg <= count_reg[IDX_W-1:0];
            OP_POP_KEY: begin
                key_reg <= rd_a_reg;
                pos_reg <= '0;
            end
            OP_UP_STEP:   pos_reg <= parent_idx;
            OP_DOWN_STEP: pos_reg <= pick_idx;
            default: begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= ERR_OK;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_LOAD:      err_reg   <= ERR_OK;
                OP_ERR_FULL:  err_reg   <= ERR_FULL;
                OP_ERR_EMPTY: err_reg   <= ERR_EMPTY;
                OP_PUSH_INIT: count_reg <= count_reg + CNT_W'(1);
                OP_POP_INIT:  count_reg <= cnt_dec;
                default: begin
                    err_reg <= err_reg;
                end
            endcase
            if (cmd.op == OP_RESULT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_RESULT) begin
            out_top_reg   <= status.empty ? 32'd0 : root_ext[31:0];
            out_empty_reg <= status.empty;
            out_count_reg <= 7'(count_reg);
            out_err_reg   <= err_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_err_reg, out_count_reg, out_empty_reg, out_top_reg};

endmodule

### sv/binary_min_heap_queue_core.sv
// Channel   Direction  tdata (low bit first)                     tuser
// s_        in         value[31:0]                               kind[0] (0 push, 1 pop)
// m_        out        top_value[31:0] is_empty[32]              -
//                      entry_count[39:33] error_code[41:40]
//
// One operation at a time. A push moves its key up from the new leaf and a pop moves the
// last key down from the root, by up to 6 levels; each level is a heap memory read
// followed by a compare and write back. Errors go from the decode state straight to
// the result state. s_tready returns in the same cycle that m_tvalid rises. Reset clears
// the entry count, the error code, the controller and the output valid, not the heap
// memory. A new item is taken while a result is pending; its result waits in the last
// state until the previous transfer is taken.
module binary_min_heap_queue_core
    import bmhq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // top_value, is_empty, entry_count, error_code
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bmhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmhq_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### tb/binary_min_heap_queue_core_tb.sv
`timescale 1ns / 100ps

module binary_min_heap_queue_core_tb
    import bmhq_pkg::*;
();

    localparam int RUN_ITEMS  = 1600;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic signed [KEY_WIDTH-1:0] top;
        logic                        empty;
        logic [CNT_W-1:0]            count;
        err_t                        err;
    } heap_status_t;

    class min_heap_tracker;
        logic signed [KEY_WIDTH-1:0] keys [CAPACITY];
        int                          count;
        heap_status_t                status_due [$];
        int                          mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        task flag_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void swap_keys(int a, int b);
            logic signed [KEY_WIDTH-1:0] t;
            t       = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void note_operation(logic kind, logic [31:0] value);
            heap_status_t st;
            int           pos;
            int           up;
            int           left;
            int           pick;
            st.err = ERR_OK;
            if (kind == KIND_PUSH) begin
                if (count >= CAPACITY) begin
                    st.err = ERR_FULL;
                end else begin
                    keys[count] = value;
                    pos = count;
                    count++;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (keys[up] <= keys[pos]) break;
                        swap_keys(up, pos);
                        pos = up;
                    end
                end
            end else begin
                if (count == 0) begin
                    st.err = ERR_EMPTY;
                end else begin
                    count--;
                    keys[0] = keys[count];
                    pos = 0;
                    forever begin
                        left = 2 * pos + 1;
                        if (left >= count) break;
                        pick = left;
                        if (left + 1 < count && keys[left] > keys[left + 1]) pick = left + 1;
                        if (keys[pos] <= keys[pick]) break;
                        swap_keys(pos, pick);
                        pos = pick;
                    end
                end
            end
            st.top   = (count > 0) ? keys[0] : '0;
            st.empty = (count == 0);
            st.count = count[CNT_W-1:0];
            status_due.push_back(st);
        endfunction

        task check_status(logic [47:0] word);
            heap_status_t st;
            if (status_due.size() == 0) begin
                flag_mismatch($sformatf("result 0x%012h with no operation pending", word));
                return;
            end
            st = status_due.pop_front();
            if (word[31:0] !== st.top)
                flag_mismatch($sformatf("top_value %0d, expected %0d",
                                        $signed(word[31:0]), st.top));
            if (word[32] !== st.empty)
                flag_mismatch($sformatf("is_empty %b, expected %b", word[32], st.empty));
            if (word[39:33] !== st.count)
                flag_mismatch($sformatf("entry_count %0d, expected %0d",
                                        word[39:33], st.count));
            if (word[41:40] !== st.err)
                flag_mismatch($sformatf("error_code %0d, expected %s",
                                        word[41:40], st.err.name()));
        endtask

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    min_heap_tracker tracker = new();
    bit              quiet;
    int              hold_left = 0;
    int              idle_cycles = 0;
    int              items_sent;

    binary_min_heap_queue_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 15) - 8;
            7:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default:    return $urandom_range(0, 1) ? $urandom_range(0, 3) - 2
                                                    : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic send_item(logic kind, logic [31:0] value);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= kind;
        s_tdata    <= value;
        do @(posedge aclk); while (!s_tready);
        tracker.note_operation(kind, value);
        items_sent++;
    endtask

    task automatic send_random(int push_pct);
        if ($urandom_range(0, 99) < push_pct) send_item(KIND_PUSH, pick_key());
        else send_item(KIND_POP, $urandom);
    endtask

    // result side: check each transfer, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_status(m_tdata);
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_tready  <= 1'b0;
            hold_left <= stall_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("binary_min_heap_queue_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int mode;
        int extra;
        int n;
        quiet       = 1'b0;
        items_sent  = 0;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // pop when empty, extreme and equal keys, drain past empty
        send_item(KIND_POP, 32'hffff_ffff);
        send_item(KIND_PUSH, 32'h7fff_ffff);
        send_item(KIND_PUSH, 32'h8000_0000);
        send_item(KIND_PUSH, 32'h0000_0000);
        send_item(KIND_PUSH, 32'hffff_ffff);
        send_item(KIND_PUSH, 32'hffff_ffff);
        send_item(KIND_PUSH, 32'h0000_0005);
        send_item(KIND_PUSH, 32'h0000_0005);
        send_item(KIND_PUSH, 32'h8000_0000);
        repeat (9) send_item(KIND_POP, 32'h0);
        send_item(KIND_PUSH, 32'h0000_0003);
        send_item(KIND_PUSH, 32'h0000_0001);
        send_item(KIND_PUSH, 32'h0000_0001);
        repeat (3) send_item(KIND_POP, 32'h1234_5678);

        while (items_sent < RUN_ITEMS) begin
            mode  = $urandom_range(0, 3);
            quiet = ($urandom_range(0, 4) == 0);
            case (mode)
                0: begin
                    // fill to capacity, then push into a full heap
                    while (tracker.count < CAPACITY) send_random(92);
                    extra = $urandom_range(1, 4);
                    repeat (extra) send_item(KIND_PUSH, pick_key());
                end
                1: begin
                    // drain to empty, then pop an empty heap
                    while (tracker.count > 0) send_random(8);
                    extra = $urandom_range(1, 3);
                    repeat (extra) send_item(KIND_POP, $urandom);
                end
                default: begin
                    n = $urandom_range(30, 120);
                    repeat (n) send_random(50);
                end
            endcase
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("binary_min_heap_queue_core verification clean");
        end else begin
            $display("binary_min_heap_queue_core verification failed");
        end
        $finish;
    end

endmodule

### files.f
sv/bmhq_pkg.sv
sv/bmhq_ctrl.sv
sv/bmhq_datapath.sv
sv/binary_min_heap_queue_core.sv
tb/binary_min_heap_queue_core_tb.sv
